### rtl/core/rbsv_pkg.sv
// ----------------------------------------------------------------------------
// rbsv_pkg
// shared types and constants of the redundant byte store with voted read
// ----------------------------------------------------------------------------
package rbsv_pkg;

  localparam int ADDR_W = 6;
  localparam int DATA_W = 8;

  localparam logic [DATA_W-1:0] ERASED = 8'hFF;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_READ  = 1'b1;

  localparam logic CFG_MARKER_ADDR = 1'b0;
  localparam logic CFG_MARKER_VAL  = 1'b1;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MARK,
    ST_DRD,
    ST_DCMP,
    ST_VRD,
    ST_VCAP,
    ST_VOTE,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic              done;
    logic              fix;
    logic [DATA_W-1:0] winner;
  } vote_res_t;

endpackage

### rtl/core/rbsv_ram.sv
// ----------------------------------------------------------------------------
// rbsv_ram
// generic single-port synchronous ram with registered read
// ----------------------------------------------------------------------------
module rbsv_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 192
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata_r <= mem[addr];
  end

  assign rdata = rdata_r;

endmodule

### rtl/core/rbsv_vote.sv
// ----------------------------------------------------------------------------
// rbsv_vote
// two-stage majority vote over the fetched copies, earliest copy wins a tie
// ----------------------------------------------------------------------------
module rbsv_vote #(
  parameter int COPIES = 3
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    start,
  input  logic [COPIES-1:0][rbsv_pkg::DATA_W-1:0] vals,
  output rbsv_pkg::vote_res_t                     res
);

  localparam int KW = $clog2(COPIES + 1);

  logic [COPIES-1:0][KW-1:0] cnt_nxt;
  logic [COPIES-1:0][KW-1:0] cnt_r;
  logic                      v1_r;
  rbsv_pkg::vote_res_t       res_nxt;
  rbsv_pkg::vote_res_t       res_r;
  logic [KW-1:0]             best;
  logic [rbsv_pkg::DATA_W-1:0] win;

  // stage one: occurrence count per copy
  always_comb begin
    for (int i = 0; i < COPIES; i++) begin
      cnt_nxt[i] = '0;
      for (int j = 0; j < COPIES; j++) begin
        if (vals[j] == vals[i]) begin
          cnt_nxt[i] = cnt_nxt[i] + KW'(1);
        end
      end
    end
  end

  // stage two: highest count, strict compare keeps the earliest copy
  always_comb begin
    best = '0;
    win  = vals[0];
    for (int i = 0; i < COPIES; i++) begin
      if (cnt_r[i] > best) begin
        best = cnt_r[i];
        win  = vals[i];
      end
    end
    res_nxt.done   = v1_r;
    res_nxt.fix    = (best != KW'(COPIES));
    res_nxt.winner = win;
  end

  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    if (!rst_n) begin
      v1_r       <= 1'b0;
      res_r.done <= 1'b0;
    end else begin
      v1_r       <= start;
      res_r.done <= res_nxt.done;
    end
    res_r.fix    <= res_nxt.fix;
    res_r.winner <= res_nxt.winner;
  end

  assign res = res_r;

endmodule

### rtl/core/redundant_byte_store_vote.sv
// ----------------------------------------------------------------------------
// redundant_byte_store_vote
// byte store kept in COPIES replicas with marker write and voted, scrubbing read
// ----------------------------------------------------------------------------
// in channel: one command word per access, tuser selects write or voted read.
// out channel: exactly one result word per command.
// cfg channel: marker address and marker value, taken only while idle or sweeping.
// all replicas live in one single-port ram, one access per cycle.
// write: COPIES marker writes, then a read and a write per copy.
// read: a read and a capture per copy, then the vote, then,
//   when the copies disagree, the full write sequence with the voted byte.
// one command at a time; in_tready is high only when the sequencer is idle,
//   so the next command can be taken in the cycle after the result is loaded.
// a finished result sits in the output register; a new command is taken
// while it waits, but the next result holds until out_tready.
// after reset the ram is swept to 255 before the
// first command is taken; cfg writes are taken during the sweep.
// ----------------------------------------------------------------------------
module redundant_byte_store_vote #(
  parameter int COPIES = 3,
  parameter int SIZE   = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,  // address[5:0], write_value[13:6], zero fill
  input  logic        in_tuser,  // cmd
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata, // read_value[7:0], corrected[8], changed[9], zero fill
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_data
);

  localparam int DEPTH = COPIES * SIZE;
  localparam int MAW   = $clog2(DEPTH);
  localparam int AW    = $clog2(SIZE);
  localparam int CW    = (COPIES > 1) ? $clog2(COPIES) : 1;
  localparam int MW    = 15;
  localparam int DW    = rbsv_pkg::DATA_W;

  function automatic logic [AW-1:0] mod_size(input logic [rbsv_pkg::ADDR_W-1:0] v);
    logic [MW-1:0] r;
    logic [MW-1:0] d;
    r = MW'(v);
    for (int k = rbsv_pkg::ADDR_W - 1; k >= 0; k--) begin
      d = MW'(SIZE) << k;
      if (r >= d) begin
        r = r - d;
      end
    end
    return AW'(r);
  endfunction

  rbsv_pkg::state_t state_r, state_nxt;

  logic [rbsv_pkg::ADDR_W-1:0] maddr_r;
  logic [DW-1:0]               mval_r;
  logic [AW-1:0]               maddr_mod;

  logic [MAW-1:0]           base_r, base_nxt;
  logic [CW-1:0]            cnt_r, cnt_nxt;
  logic [AW-1:0]            addr_r, addr_nxt;
  logic [DW-1:0]            dval_r, dval_nxt;
  logic                     cmd_r, cmd_nxt;
  logic                     any_r, any_nxt;
  logic                     fix_r, fix_nxt;
  logic [COPIES-1:0][DW-1:0] vals_r, vals_nxt;

  logic           out_valid_r, out_valid_nxt;
  logic [15:0]    out_data_r, out_data_nxt;

  logic           ram_we;
  logic [MAW-1:0] ram_addr;
  logic [DW-1:0]  ram_wdata;
  logic [DW-1:0]  ram_rdata;

  logic                vote_start;
  rbsv_pkg::vote_res_t vote_res;
  logic                last_copy;
  logic                last_clear;

  assign maddr_mod  = mod_size(maddr_r);
  assign last_copy  = (cnt_r == CW'(COPIES - 1));
  assign last_clear = (base_r == MAW'(DEPTH - 1));

  assign cfg_ready = (state_r == rbsv_pkg::ST_IDLE) || (state_r == rbsv_pkg::ST_CLEAR);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      maddr_r <= '0;
      mval_r  <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        rbsv_pkg::CFG_MARKER_ADDR: maddr_r <= cfg_data[rbsv_pkg::ADDR_W-1:0];
        rbsv_pkg::CFG_MARKER_VAL:  mval_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  rbsv_ram #(
    .WIDTH (DW),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  rbsv_vote #(
    .COPIES (COPIES)
  ) u_vote (
    .clk   (clk),
    .rst_n (rst_n),
    .start (vote_start),
    .vals  (vals_r),
    .res   (vote_res)
  );

  always_comb begin
    state_nxt     = state_r;
    base_nxt      = base_r;
    cnt_nxt       = cnt_r;
    addr_nxt      = addr_r;
    dval_nxt      = dval_r;
    cmd_nxt       = cmd_r;
    any_nxt       = any_r;
    fix_nxt       = fix_r;
    vals_nxt      = vals_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    in_tready     = 1'b0;
    ram_we        = 1'b0;
    ram_addr      = base_r + MAW'(addr_r);
    ram_wdata     = dval_r;
    vote_start    = 1'b0;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      rbsv_pkg::ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_addr  = base_r;
        ram_wdata = rbsv_pkg::ERASED;
        base_nxt  = base_r + MAW'(1);
        if (last_clear) begin
          base_nxt  = '0;
          state_nxt = rbsv_pkg::ST_IDLE;
        end
      end
      rbsv_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd_nxt  = in_tuser;
          addr_nxt = mod_size(in_tdata[rbsv_pkg::ADDR_W-1:0]);
          dval_nxt = in_tdata[rbsv_pkg::ADDR_W +: DW];
          any_nxt  = 1'b0;
          fix_nxt  = 1'b0;
          base_nxt = '0;
          cnt_nxt  = '0;
          if (in_tuser == rbsv_pkg::CMD_READ) begin
            state_nxt = rbsv_pkg::ST_VRD;
          end else begin
            state_nxt = rbsv_pkg::ST_MARK;
          end
        end
      end
      rbsv_pkg::ST_MARK: begin
        ram_we    = 1'b1;
        ram_addr  = base_r + MAW'(maddr_mod);
        ram_wdata = mval_r;
        base_nxt  = base_r + MAW'(SIZE);
        cnt_nxt   = cnt_r + CW'(1);
        if (last_copy) begin
          base_nxt  = '0;
          cnt_nxt   = '0;
          state_nxt = rbsv_pkg::ST_DRD;
        end
      end
      rbsv_pkg::ST_DRD: begin
        state_nxt = rbsv_pkg::ST_DCMP;
      end
      rbsv_pkg::ST_DCMP: begin
        ram_we = 1'b1;
        if (ram_rdata != dval_r) begin
          any_nxt = 1'b1;
        end
        base_nxt  = base_r + MAW'(SIZE);
        cnt_nxt   = cnt_r + CW'(1);
        state_nxt = rbsv_pkg::ST_DRD;
        if (last_copy) begin
          state_nxt = rbsv_pkg::ST_DONE;
        end
      end
      rbsv_pkg::ST_VRD: begin
        state_nxt = rbsv_pkg::ST_VCAP;
      end
      rbsv_pkg::ST_VCAP: begin
        vals_nxt[cnt_r] = ram_rdata;
        base_nxt        = base_r + MAW'(SIZE);
        cnt_nxt         = cnt_r + CW'(1);
        state_nxt       = rbsv_pkg::ST_VRD;
        if (last_copy) begin
          state_nxt = rbsv_pkg::ST_VOTE;
        end
      end
      rbsv_pkg::ST_VOTE: begin
        vote_start = !vote_res.done;
        if (vote_res.done) begin
          dval_nxt = vote_res.winner;
          fix_nxt  = vote_res.fix;
          base_nxt = '0;
          cnt_nxt  = '0;
          if (vote_res.fix) begin
            state_nxt = rbsv_pkg::ST_MARK;
          end else begin
            state_nxt = rbsv_pkg::ST_DONE;
          end
        end
      end
      rbsv_pkg::ST_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '0;
          if (cmd_r == rbsv_pkg::CMD_READ) begin
            out_data_nxt[DW-1:0] = dval_r;
            out_data_nxt[DW]     = fix_r;
          end else begin
            out_data_nxt[DW+1]   = any_r;
          end
          state_nxt = rbsv_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = rbsv_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rbsv_pkg::ST_CLEAR;
      base_r      <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      base_r      <= base_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
    addr_r     <= addr_nxt;
    dval_r     <= dval_nxt;
    cmd_r      <= cmd_nxt;
    any_r      <= any_nxt;
    fix_r      <= fix_nxt;
    vals_r     <= vals_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

### tb/redundant_byte_store_vote_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// redundant_byte_store_vote_checker
// watches the command, result and marker channels of the replicated byte
// store, keeps its own image of every replica and of the marker settings,
// works out the result word of each accepted command and compares each
// accepted result word, field by field, with the oldest one still due
// ----------------------------------------------------------------------------
module redundant_byte_store_vote_checker #(
  parameter int COPIES = 3,
  parameter int SIZE   = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [15:0] in_tdata,  // address[5:0], write_value[13:6], zero fill
  input  logic        in_tuser,  // cmd
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [15:0] out_tdata, // read_value[7:0], corrected[8], changed[9], zero fill
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_data,
  output int          errors,
  output int          pending
);

  localparam int DW = rbsv_pkg::DATA_W;
  localparam int AW = rbsv_pkg::ADDR_W;

  typedef struct packed {
    logic [DW-1:0] read_value;
    logic          corrected;
    logic          changed;
  } access_result_t;

  logic [DW-1:0]  replica [COPIES][SIZE];
  logic [AW-1:0]  marker_addr;
  logic [DW-1:0]  marker_val;
  access_result_t due_results[$];
  int             fail_count = 0;

  assign errors = fail_count;

  // marker byte first in every copy, then the data byte
  function automatic bit replica_write(input int unsigned addr,
                                       input logic [DW-1:0] val);
    int unsigned m;
    bit any;
    m = marker_addr % SIZE;
    any = 1'b0;
    for (int c = 0; c < COPIES; c++) replica[c][m] = marker_val;
    for (int c = 0; c < COPIES; c++) begin
      if (replica[c][addr] != val) begin
        replica[c][addr] = val;
        any = 1'b1;
      end
    end
    return any;
  endfunction

  // highest count wins, earliest copy on a tie
  function automatic bit replica_vote(input int unsigned addr,
                                      output logic [DW-1:0] winner);
    int best;
    int best_idx;
    int cnt;
    best = 0;
    best_idx = 0;
    for (int i = 0; i < COPIES; i++) begin
      cnt = 0;
      for (int j = 0; j < COPIES; j++) begin
        if (replica[j][addr] == replica[i][addr]) cnt++;
      end
      if (cnt > best) begin
        best = cnt;
        best_idx = i;
      end
    end
    winner = replica[best_idx][addr];
    return best != COPIES;
  endfunction

  function automatic access_result_t predict_access(input logic cmd,
                                                    input logic [AW-1:0] a,
                                                    input logic [DW-1:0] v);
    access_result_t r;
    int unsigned addr;
    logic [DW-1:0] w;
    addr = a % SIZE;
    r = '0;
    if (cmd == rbsv_pkg::CMD_WRITE) begin
      r.changed = replica_write(addr, v);
    end else begin
      r.corrected = replica_vote(addr, w);
      r.read_value = w;
      if (r.corrected) void'(replica_write(addr, w));
    end
    return r;
  endfunction

  task automatic note_failure(input string what);
    if (fail_count < 10) $display("mismatch: %s", what);
    fail_count++;
  endtask

  always @(posedge clk) begin : watch
    access_result_t got;
    access_result_t want;
    if (!rst_n) begin
      foreach (replica[c, a]) replica[c][a] = rbsv_pkg::ERASED;
      marker_addr = '0;
      marker_val = '0;
      due_results.delete();
      pending <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == rbsv_pkg::CFG_MARKER_ADDR) marker_addr = cfg_data[AW-1:0];
        else marker_val = cfg_data;
      end
      if (out_tvalid && out_tready) begin
        got.read_value = out_tdata[7:0];
        got.corrected = out_tdata[8];
        got.changed = out_tdata[9];
        if (due_results.size() == 0) begin
          note_failure($sformatf({"result word with nothing due: ",
                                  "read_value %02h corrected %0b changed %0b"},
                                 got.read_value, got.corrected, got.changed));
        end else begin
          want = due_results.pop_front();
          if (got.read_value != want.read_value || got.corrected != want.corrected ||
              got.changed != want.changed) begin
            note_failure($sformatf({"expected read_value %02h corrected %0b changed %0b, ",
                                    "got read_value %02h corrected %0b changed %0b"},
                                   want.read_value, want.corrected, want.changed,
                                   got.read_value, got.corrected, got.changed));
          end
        end
      end
      if (in_tvalid && in_tready) begin
        due_results.push_back(predict_access(in_tuser, in_tdata[5:0], in_tdata[13:6]));
      end
      pending <= due_results.size();
    end
  end

endmodule

### tb/redundant_byte_store_vote_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// redundant_byte_store_vote_tb
// drives write and voted-read commands into the replicated byte store under
// several marker settings, with random gaps on both channels and one long
// output hold-off that backs the store up; checking sits in the checker
// beside the block, this module makes stimulus and gives the verdict
// ----------------------------------------------------------------------------
module redundant_byte_store_vote_tb;

  localparam int COPIES       = 3;
  localparam int SIZE         = 64;
  localparam int AW           = rbsv_pkg::ADDR_W;
  localparam int DW           = rbsv_pkg::DATA_W;
  localparam int DRAIN        = 5 * COPIES + 8;
  localparam int LIMIT        = 900_000;
  localparam int PHASE_ITEMS  = 390;
  localparam int HOLD_CYCLES  = 400;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata = '0;
  logic        in_tuser = rbsv_pkg::CMD_WRITE;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_index = rbsv_pkg::CFG_MARKER_ADDR;
  logic [7:0]  cfg_data = '0;

  int errors;
  int pending;
  int cycle_count = 0;
  int hold_req = 0;
  int hold_done = 0;
  int stall_left = 0;
  bit rx_steady = 1'b0;
  bit tx_steady = 1'b0;
  int n_reads = 0;
  int n_writes = 0;
  int n_settings = 0;
  int n_marker_hits = 0;

  always #2 clk = ~clk;

  redundant_byte_store_vote #(.COPIES(COPIES), .SIZE(SIZE)) u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  redundant_byte_store_vote_checker #(.COPIES(COPIES), .SIZE(SIZE)) u_checker (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .errors(errors), .pending(pending)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // mostly short gaps, now and then a long one
  function automatic int gap_len();
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
    return $urandom_range(8, 60);
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (stall_left > 0) begin
      out_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (hold_done != hold_req) begin
      // long hold-off so the store fills and stops taking commands
      hold_done <= hold_req;
      stall_left <= HOLD_CYCLES;
      out_tready <= 1'b0;
    end else if (!rx_steady && $urandom_range(0, 3) == 0) begin
      stall_left <= gap_len() - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  task automatic send_access(input logic cmd, input logic [AW-1:0] addr,
                             input logic [DW-1:0] val);
    int gap;
    gap = (!tx_steady && $urandom_range(0, 2) == 0) ? gap_len() : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= cmd;
    in_tdata <= {2'b00, val, addr};
    do @(posedge clk); while (!in_tready);
    if (cmd == rbsv_pkg::CMD_READ) n_reads++;
    else n_writes++;
  endtask

  task automatic write_marker(input logic [AW-1:0] maddr, input logic [DW-1:0] mval);
    cfg_valid <= 1'b1;
    cfg_index <= rbsv_pkg::CFG_MARKER_ADDR;
    cfg_data <= {2'b00, maddr};
    do @(posedge clk); while (!cfg_ready);
    cfg_index <= rbsv_pkg::CFG_MARKER_VAL;
    cfg_data <= mval;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    n_settings++;
  endtask

  task automatic settle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  task automatic random_accesses(input int count, input logic [AW-1:0] maddr);
    logic          c;
    logic [AW-1:0] a;
    logic [DW-1:0] v;
    for (int i = 0; i < count; i++) begin
      c = ($urandom_range(0, 1) == 1) ? rbsv_pkg::CMD_READ : rbsv_pkg::CMD_WRITE;
      case ($urandom_range(0, 9))
        0: a = maddr;
        1, 2, 3, 4: a = AW'($urandom_range(0, 7));
        default: a = AW'($urandom());
      endcase
      case ($urandom_range(0, 9))
        0: v = 8'h00;
        1: v = rbsv_pkg::ERASED;
        2: v = 8'hA5;
        default: v = DW'($urandom());
      endcase
      if (a == maddr) n_marker_hits++;
      send_access(c, a, v);
    end
  endtask

  initial begin
    logic [AW-1:0] maddr;
    logic [DW-1:0] mval;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // reset marker settings: address 0, value 0
    send_access(rbsv_pkg::CMD_WRITE, 6'd7, 8'h12);
    send_access(rbsv_pkg::CMD_READ, 6'd0, 8'hFF);
    send_access(rbsv_pkg::CMD_READ, 6'd7, 8'h00);
    send_access(rbsv_pkg::CMD_WRITE, 6'd0, 8'hFF);
    send_access(rbsv_pkg::CMD_READ, 6'd0, 8'h5A);
    settle();

    write_marker(6'd63, 8'hA5);
    send_access(rbsv_pkg::CMD_READ, 6'd63, 8'h00);
    send_access(rbsv_pkg::CMD_WRITE, 6'd63, 8'h3C);
    // data on the marker byte, equal to the marker value
    send_access(rbsv_pkg::CMD_WRITE, 6'd63, 8'hA5);
    send_access(rbsv_pkg::CMD_READ, 6'd63, 8'hFF);
    send_access(rbsv_pkg::CMD_WRITE, 6'd0, 8'h00);
    send_access(rbsv_pkg::CMD_WRITE, 6'd0, 8'h00);
    send_access(rbsv_pkg::CMD_READ, 6'd0, 8'hFF);
    send_access(rbsv_pkg::CMD_WRITE, 6'd42, 8'hFF);
    send_access(rbsv_pkg::CMD_WRITE, 6'd21, 8'h55);
    send_access(rbsv_pkg::CMD_WRITE, 6'd42, 8'hAA);
    send_access(rbsv_pkg::CMD_READ, 6'd21, 8'h00);
    send_access(rbsv_pkg::CMD_READ, 6'd42, 8'h00);
    send_access(rbsv_pkg::CMD_READ, 6'd33, 8'h80);
    send_access(rbsv_pkg::CMD_WRITE, 6'd33, 8'h7F);
    send_access(rbsv_pkg::CMD_READ, 6'd33, 8'h01);
    settle();

    for (int p = 0; p < 5; p++) begin
      case (p)
        0: begin maddr = 6'd0;  mval = 8'hFF; end
        1: begin maddr = 6'd63; mval = 8'h00; end
        2: begin maddr = AW'($urandom()); mval = DW'($urandom()); end
        3: begin maddr = 6'd0;  mval = 8'h00; end
        default: begin maddr = 6'd31; mval = 8'h5A; end
      endcase
      write_marker(maddr, mval);
      tx_steady = (p == 1 || p == 3);
      rx_steady <= (p == 1);
      if (p == 3) hold_req <= hold_req + 1;
      random_accesses(PHASE_ITEMS, maddr);
      settle();
    end

    $display("ran %0d writes and %0d voted reads under %0d marker settings",
             n_writes, n_reads, n_settings + 1);
    $display("%0d random commands hit the marker byte; one output hold-off of %0d cycles",
             n_marker_hits, HOLD_CYCLES);
    if (errors == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
